[hw/rtl/fp8a_pkg.sv]
// ----------------------------------------------------------------------------
// FP8 E5M2 adder package
// Shared constants and payload types for the E5M2 adder.
// ----------------------------------------------------------------------------
package fp8a_pkg;

    localparam logic [7:0] NAN_CODE   = 8'h7d;
    localparam logic [7:0] POS_INF    = 8'h7c;
    localparam logic [7:0] NEG_INF    = 8'hfc;
    localparam logic [2:0] HIDDEN_ONE = 3'h4;
    localparam logic [4:0] EXP_MAX    = 5'h1f;
    localparam int         TOP_POS    = 17;
    localparam int         GUARD      = 15;
    localparam int         MW         = TOP_POS + 2;

    typedef struct packed {
        logic [7:0] operand_a;
        logic [7:0] operand_b;
    } t_in_req;

    typedef struct packed {
        logic [7:0] sum_value;
    } t_out_req;

endpackage

[hw/rtl/fp8a_in_if.sv]
// ----------------------------------------------------------------------------
// FP8 E5M2 adder operand channel
// Valid/ready channel that carries one pair of operands per request.
// ----------------------------------------------------------------------------
interface fp8a_in_if;
    logic              valid;
    logic              ready;
    fp8a_pkg::t_in_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/fp8a_out_if.sv]
// ----------------------------------------------------------------------------
// FP8 E5M2 adder result channel
// Valid/ready channel that carries one sum per request.
// ----------------------------------------------------------------------------
interface fp8a_out_if;
    logic               valid;
    logic               ready;
    fp8a_pkg::t_out_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/fp8_e5m2_adder_core.sv]
// ----------------------------------------------------------------------------
// FP8 E5M2 adder core
// Adds two E5M2 values in a four-stage pipeline with round to nearest even.
// ----------------------------------------------------------------------------
// One request enters per cycle while the output is not stalled, and its sum
// passes through align, add, normalise and round, one register stage each;
// the pipeline advances whenever the last stage is empty or being taken, so a
// stalled output holds every stage in place. NaN results are 0x7d.
module fp8_e5m2_adder_core (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fp8a_in_if.sink    i_req,
    fp8a_out_if.source o_rsp
);

    localparam int MW = fp8a_pkg::MW;

    logic w_adv;
    assign w_adv = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    // Stage 1: decode and align.
    logic [7:0] w_a, w_b;
    logic [4:0] w_ea, w_eb;
    logic [1:0] w_ma, w_mb;
    logic       w_nan_a, w_nan_b, w_inf_a, w_inf_b, w_zero_a, w_zero_b;
    logic [4:0] w_xa, w_xb, w_e1, w_sh;
    logic [MW-1:0] w_fa, w_fb, w_al_a, w_al_b;
    logic       w_sp1;
    logic [7:0] w_spv1;

    always_comb begin
        w_a = i_req.payload.operand_a;
        w_b = i_req.payload.operand_b;
        w_ea = w_a[6:2];
        w_eb = w_b[6:2];
        w_ma = w_a[1:0];
        w_mb = w_b[1:0];
        w_nan_a = (w_ea == fp8a_pkg::EXP_MAX) && (w_ma != 2'd0);
        w_nan_b = (w_eb == fp8a_pkg::EXP_MAX) && (w_mb != 2'd0);
        w_inf_a = (w_ea == fp8a_pkg::EXP_MAX) && (w_ma == 2'd0);
        w_inf_b = (w_eb == fp8a_pkg::EXP_MAX) && (w_mb == 2'd0);
        w_zero_a = (w_ea == 5'd0) && (w_ma == 2'd0);
        w_zero_b = (w_eb == 5'd0) && (w_mb == 2'd0);
        w_sp1 = 1'b1;
        if (w_nan_a || w_nan_b) begin
            w_spv1 = fp8a_pkg::NAN_CODE;
        end else if (w_inf_a && w_inf_b && (w_a[7] != w_b[7])) begin
            w_spv1 = fp8a_pkg::NAN_CODE;
        end else if (w_inf_a) begin
            w_spv1 = w_a;
        end else if (w_inf_b) begin
            w_spv1 = w_b;
        end else if (w_zero_a) begin
            w_spv1 = w_b;
        end else if (w_zero_b) begin
            w_spv1 = w_a;
        end else begin
            w_sp1 = 1'b0;
            w_spv1 = 8'd0;
        end
        w_xa = (w_ea == 5'd0) ? 5'd1 : w_ea;
        w_xb = (w_eb == 5'd0) ? 5'd1 : w_eb;
        w_fa = {1'b0, (w_ea != 5'd0), w_ma, {fp8a_pkg::GUARD{1'b0}}};
        w_fb = {1'b0, (w_eb != 5'd0), w_mb, {fp8a_pkg::GUARD{1'b0}}};
        w_al_a = w_fa;
        w_al_b = w_fb;
        if (w_xa > w_xb) begin
            w_e1 = w_xa;
            w_sh = w_xa - w_xb;
            w_al_b = w_fb >> w_sh;
        end else begin
            w_e1 = w_xb;
            w_sh = w_xb - w_xa;
            w_al_a = w_fa >> w_sh;
        end
    end

    logic          r_v1, r_sp1, r_sa1, r_sb1;
    logic [7:0]    r_spv1;
    logic [4:0]    r_e1;
    logic [MW-1:0] r_ma1, r_mb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_req.valid;
        end
        if (w_adv) begin
            r_sp1 <= w_sp1;
            r_spv1 <= w_spv1;
            r_sa1 <= w_a[7];
            r_sb1 <= w_b[7];
            r_e1 <= w_e1;
            r_ma1 <= w_al_a;
            r_mb1 <= w_al_b;
        end
    end

    // Stage 2: add or subtract magnitudes.
    logic [MW-1:0] w_m2;
    logic          w_s2;

    always_comb begin
        if (r_sa1 != r_sb1) begin
            if (r_ma1 > r_mb1) begin
                w_m2 = r_ma1 - r_mb1;
                w_s2 = r_sa1;
            end else begin
                w_m2 = r_mb1 - r_ma1;
                w_s2 = r_sb1;
            end
        end else begin
            w_m2 = r_ma1 + r_mb1;
            w_s2 = r_sa1;
        end
    end

    logic          r_v2, r_sp2, r_s2;
    logic [7:0]    r_spv2;
    logic [4:0]    r_e2;
    logic [MW-1:0] r_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r_sp2 <= r_sp1;
            r_spv2 <= r_spv1;
            r_s2 <= w_s2;
            r_e2 <= r_e1;
            r_m2 <= w_m2;
        end
    end

    // Stage 3: normalise by leading-one position.
    logic [4:0]    w_lz;
    logic [6:0]    w_e3;
    logic [MW-1:0] w_m3;
    logic          w_st3, w_zero3;

    always_comb begin
        w_lz = 5'd0;
        for (int i = 0; i <= fp8a_pkg::TOP_POS; i++) begin
            if (r_m2[i]) begin
                w_lz = 5'(fp8a_pkg::TOP_POS - i);
            end
        end
        w_zero3 = (r_m2 == '0);
        w_st3 = 1'b0;
        if (r_m2[MW-1]) begin
            w_e3 = {2'b00, r_e2} + 7'd1;
            w_st3 = r_m2[0];
            w_m3 = r_m2 >> 1;
        end else begin
            w_e3 = {2'b00, r_e2} - {2'b00, w_lz};
            w_m3 = r_m2 << w_lz;
        end
    end

    logic          r_v3, r_sp3, r_s3, r_st3;
    logic [7:0]    r_spv3;
    logic [6:0]    r_e3;
    logic [MW-1:0] r_m3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
        if (w_adv) begin
            r_sp3 <= r_sp2 || w_zero3;
            r_spv3 <= r_sp2 ? r_spv2 : 8'd0;
            r_s3 <= r_s2;
            r_st3 <= w_st3;
            r_e3 <= w_e3;
            r_m3 <= w_m3;
        end
    end

    // Stage 4: round and pack.
    logic       w_sticky, w_rnd, w_lsb;
    logic [3:0] w_r;
    logic [6:0] w_e4;
    logic [7:0] w_sum;

    always_comb begin
        w_lsb = r_m3[fp8a_pkg::GUARD];
        w_rnd = r_m3[fp8a_pkg::GUARD-1];
        w_sticky = r_st3 || (r_m3[fp8a_pkg::GUARD-2:0] != '0);
        w_r = {1'b0, r_m3[fp8a_pkg::TOP_POS:fp8a_pkg::GUARD]}
            + {3'd0, w_rnd && (w_lsb || w_sticky)};
        w_e4 = r_e3;
        if (w_r[3]) begin
            w_e4 = r_e3 + 7'd1;
            w_r = w_r >> 1;
        end
        if (r_sp3) begin
            w_sum = r_spv3;
        end else if (!w_e4[6] && (w_e4 >= 7'd31)) begin
            w_sum = r_s3 ? fp8a_pkg::NEG_INF : fp8a_pkg::POS_INF;
        end else if (w_e4 == 7'h7f) begin
            w_sum = {r_s3, 5'd0, 2'(w_r >> 2)};
        end else if (w_e4 == 7'd0) begin
            w_sum = {r_s3, 5'd0, 2'(w_r >> 1)};
        end else if (w_e4[6]) begin
            w_sum = 8'd0;
        end else begin
            w_sum = {r_s3, w_e4[4:0], w_r[1:0]};
        end
    end

    logic       r_v4;
    logic [7:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
        if (w_adv) begin
            r_sum <= w_sum;
        end
    end

    assign o_rsp.valid = r_v4;
    assign o_rsp.payload.sum_value = r_sum;

endmodule

[hw/rtl/fp8a_checker.sv]
// ----------------------------------------------------------------------------
// FP8 E5M2 adder port checker
// Watches the ports of the adder core for handshake and latency slips.
// ----------------------------------------------------------------------------
module fp8a_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [7:0] i_sum
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sum))
        else $error("Stalled result changed.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stage.");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_ready ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready |=> i_out_valid)
        else $error("Request lost in the pipeline.");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

endmodule

bind fp8_e5m2_adder_core fp8a_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_sum       (o_rsp.payload.sum_value)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E5M2 adder testbench
// Drives operand pairs into the adder core with random gaps and output
// stalls, predicts every sum with an independent model of E5M2 addition and
// compares each returned sum with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
class sum_scoreboard;
    logic [7:0] pending_sums[$];
    int         n_errors;
    int         n_checked;

    function automatic logic [7:0] e5m2_add(logic [7:0] a, logic [7:0] b);
        logic        sa;
        logic        sb;
        logic        s;
        logic        sticky;
        logic        lsb;
        logic        rnd;
        logic [4:0]  xa;
        logic [4:0]  xb;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] m;
        int          ea;
        int          eb;
        int          e;
        int          i;
        bit          nan_a;
        bit          nan_b;
        bit          inf_a;
        bit          inf_b;
        sa = a[7];
        sb = b[7];
        xa = a[6:2];
        xb = b[6:2];
        nan_a = (xa == fp8a_pkg::EXP_MAX) && (a[1:0] != 0);
        nan_b = (xb == fp8a_pkg::EXP_MAX) && (b[1:0] != 0);
        inf_a = (xa == fp8a_pkg::EXP_MAX) && (a[1:0] == 0);
        inf_b = (xb == fp8a_pkg::EXP_MAX) && (b[1:0] == 0);
        sticky = 1'b0;
        if (nan_a || nan_b) return fp8a_pkg::NAN_CODE;
        if (inf_a && inf_b && sa != sb) return fp8a_pkg::NAN_CODE;
        if (inf_a) return a;
        if (inf_b) return b;
        if (a[6:0] == 0) return b;
        if (b[6:0] == 0) return a;
        ea = (xa == 0) ? 1 : int'(xa);
        eb = (xb == 0) ? 1 : int'(xb);
        ma = {29'd0, (xa != 0), a[1:0]} << fp8a_pkg::GUARD;
        mb = {29'd0, (xb != 0), b[1:0]} << fp8a_pkg::GUARD;
        if (ea > eb) begin
            e = ea;
            mb = mb >> (ea - eb);
        end else begin
            e = eb;
            ma = ma >> (eb - ea);
        end
        if (sa != sb) begin
            if (ma > mb) begin
                m = ma - mb;
                s = sa;
            end else begin
                m = mb - ma;
                s = sb;
            end
        end else begin
            m = ma + mb;
            s = sa;
        end
        if (m[fp8a_pkg::TOP_POS + 1]) begin
            e++;
            sticky = m[0];
            m = m >> 1;
        end else if (!m[fp8a_pkg::TOP_POS]) begin
            if (m == 0) return 8'h00;
            for (i = 0; i < fp8a_pkg::TOP_POS; i++) begin
                e--;
                m = m << 1;
                if (m[fp8a_pkg::TOP_POS]) break;
            end
        end
        lsb = m[fp8a_pkg::GUARD];
        rnd = m[fp8a_pkg::GUARD - 1];
        sticky = sticky | (|m[fp8a_pkg::GUARD - 2:0]);
        m = m >> fp8a_pkg::GUARD;
        if (rnd && (lsb || sticky)) m++;
        if (m[3]) begin
            e++;
            m = m >> 1;
        end
        if (e >= 31) return s ? fp8a_pkg::NEG_INF : fp8a_pkg::POS_INF;
        if (e == -1) begin
            e = 0;
            m = m >> 2;
        end else if (e == 0) begin
            m = m >> 1;
        end else if (e <= -2) begin
            return 8'h00;
        end
        return {s, e[4:0], m[1:0]};
    endfunction

    function void note_request(logic [7:0] a, logic [7:0] b);
        pending_sums.push_back(e5m2_add(a, b));
    endfunction

    function void check_sum(logic [7:0] got);
        logic [7:0] want;
        if (pending_sums.size() == 0) begin
            $error("sum_value: unexpected result 0x%02h", got);
            n_errors++;
            return;
        end
        want = pending_sums.pop_front();
        n_checked++;
        if (got !== want) begin
            $error("sum_value: expected 0x%02h, actual 0x%02h", want, got);
            n_errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int N_RANDOM  = 1630;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;
    int   cycle;
    bit   long_hold;

    fp8a_in_if  req_if();
    fp8a_out_if rsp_if();

    sum_scoreboard sb = new();

    fp8_e5m2_adder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        long_hold      = 1'b0;
        cycle          = 0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            sb.note_request(req_if.payload.operand_a, req_if.payload.operand_b);
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_sum(rsp_if.payload.sum_value);
        end
    end

    function automatic logic [7:0] pick_operand();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(0, 9))
            0: v[6:2] = fp8a_pkg::EXP_MAX;
            1: v[6:2] = 5'd0;
            2: v[6:2] = 5'($urandom_range(28, 30));
            3: v[6:2] = 5'($urandom_range(1, 3));
            default: ;
        endcase
        return v;
    endfunction

    // Near-cancelling pairs and pairs with close exponents exercise the
    // normalisation and rounding paths more than independent operands do.
    function automatic logic [7:0] pick_partner(logic [7:0] a);
        logic [7:0] b;
        b = pick_operand();
        case ($urandom_range(0, 3))
            0: b = {~a[7], a[6:0] ^ 7'($urandom_range(0, 3))};
            1: b[6:2] = a[6:2] + 5'($urandom_range(0, 4)) - 5'd2;
            default: ;
        endcase
        return b;
    endfunction

    task automatic send_request(logic [7:0] a, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.payload   <= {a, b};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_burst(logic [7:0] a, logic [7:0] b);
        req_if.valid   <= 1'b1;
        req_if.payload <= {a, b};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_sums.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                rsp_if.ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = $urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0;
            if (stall == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] dir_a[$];
        logic [7:0] dir_b[$];
        int k;
        dir_a = '{8'h00, 8'h80, 8'h7d, 8'h3c, 8'h7c, 8'h7c, 8'hfc, 8'h3c, 8'h3c, 8'h01,
                  8'h81, 8'h7b, 8'hfb, 8'h04, 8'h05, 8'h3d, 8'h03, 8'h07, 8'hff, 8'h02,
                  8'h4a};
        dir_b = '{8'h00, 8'h80, 8'h3c, 8'h7e, 8'hfc, 8'h7c, 8'h3c, 8'h00, 8'h80, 8'h01,
                  8'h01, 8'h7b, 8'hfb, 8'h84, 8'h84, 8'hbc, 8'h83, 8'h80, 8'h00, 8'h01,
                  8'h2a};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < dir_a.size(); k++) send_request(dir_a[k], dir_b[k]);
        req_if.valid <= 1'b0;
        wait_drained();
        repeat ($urandom_range(0, 40)) @(posedge i_clk);
        long_hold = 1'b1;
        for (k = 0; k < 40; k++) send_burst(pick_operand(), pick_operand());
        for (k = 0; k < N_RANDOM; k++) begin
            a = pick_operand();
            b = pick_partner(a);
            if ($urandom_range(0, 1)) begin
                send_request(a, b);
            end else begin
                send_burst(a, b);
            end
        end
        req_if.valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d sums covering special values, subnormals and overflow,",
                 sb.n_checked);
        $display("with random gaps, output stalls and one long back-pressure stretch.");
        if (sb.n_errors == 0 && sb.pending_sums.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/fp8a_pkg.sv
hw/rtl/fp8a_in_if.sv
hw/rtl/fp8a_out_if.sv
hw/rtl/fp8_e5m2_adder_core.sv
hw/rtl/fp8a_checker.sv
dv/tb_top.sv
